// ----- src/assert_macros.svh -----
// Assertion macros shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked every clock edge outside reset
`define SAM_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Implication checked every clock edge outside reset
`define SAM_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

// ----- src/sam_pkg.sv -----
// Package: constants, codes and types of the suffix automaton builder
`timescale 1ns / 1ps
package sam_pkg;
  localparam int MAX_TEXT = 1024;
  localparam int SYM_W    = 8;
  localparam int NSYM     = 1 << SYM_W;
  localparam int NSTATES  = 2 * MAX_TEXT;
  localparam int ST_W     = $clog2(NSTATES);
  localparam int CNT_W    = ST_W + 1;
  localparam int LEN_W    = $clog2(MAX_TEXT + 1);
  localparam int POS_W    = $clog2(MAX_TEXT);

  localparam int OP_W     = 2;
  localparam int STAT_W   = 2;
  localparam int IDX_OW   = 11;
  localparam int LEN_OW   = 11;
  localparam int POS_OW   = 10;

  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
  localparam logic [OP_W-1:0] OP_EXTEND = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
  localparam logic [STAT_W-1:0] STAT_MISS = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL = 2'd2;

  typedef logic [NSYM-1:0][ST_W-1:0] row_t;

  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic [ST_W-1:0]  link;
    logic             clone;
    logic [POS_W-1:0] fpos;
  } info_t;
endpackage

// ----- src/sam_if.sv -----
// Item channel interfaces: request and response
`timescale 1ns / 1ps
interface sam_req_if import sam_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [OP_W-1:0] opcode;
  logic [7:0]      symbol;
  logic            first;
  modport source (output valid, opcode, symbol, first, input ready);
  modport sink (input valid, opcode, symbol, first, output ready);
endinterface

interface sam_rsp_if import sam_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [IDX_OW-1:0] state_index;
  logic [LEN_OW-1:0] state_length;
  logic [POS_OW-1:0] first_end;
  logic              clone_mark;
  modport source (output valid, status, state_index, state_length, first_end, clone_mark,
                  input ready);
  modport sink (input valid, status, state_index, state_length, first_end, clone_mark,
                output ready);
endinterface

// ----- src/sam_ram.sv -----
// Simple dual-port synchronous RAM, registered read
`timescale 1ns / 1ps
module sam_ram #(
  parameter int DATA_W = 8,
  parameter int ADDR_W = 4
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);
  logic [DATA_W-1:0] mem [(1 << ADDR_W)];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- src/suffix_automaton_builder.sv -----
// Suffix automaton builder: one item in, one result item out. A clear rewrites the root.
// A query step ends at once when the query is already lost; else it reads the cursor's
// transition row and, on a hit, the info of the state reached. An extend ends with a full
// status when the automaton is full. Else it makes the new state and walks the suffix
// links, reading each visited state, plus a check of the target when the walk finds a
// transition. A clone adds a row copy and a check of each state visited while transitions
// are redirected to it. Each step waits on a registered read of the transition-row RAM
// (one 256-entry row per word) or of the state info RAM, which every suffix-link step
// goes through. The result leaves through one output register. The next item is taken
// only after that register has been handed the result, so a stalled receiver holds off
// the input. After reset the block writes the root in its init state before it takes
// items. A state's row is zeroed, or for a clone copied, when the state is created.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module suffix_automaton_builder import sam_pkg::*; (
  input logic    clk,
  input logic    rst,
  sam_req_if.sink   req,
  sam_rsp_if.source rsp
);
  typedef enum logic [12:0] {
    S_INIT  = 13'b0000000000001,
    S_IDLE  = 13'b0000000000010,
    S_QRD   = 13'b0000000000100,
    S_QINFO = 13'b0000000001000,
    S_XLAST = 13'b0000000010000,
    S_WRD   = 13'b0000000100000,
    S_WCHK  = 13'b0000001000000,
    S_FQ    = 13'b0000010000000,
    S_CCP   = 13'b0000100000000,
    S_CRD   = 13'b0001000000000,
    S_CCHK  = 13'b0010000000000,
    S_CLINK = 13'b0100000000000,
    S_FIN   = 13'b1000000000000
  } state_t;

  state_t state;
  logic from_clear;
  logic [CNT_W-1:0] cnt;
  logic [ST_W-1:0] last, cursor, cur, p, q, cl;
  logic lost;
  logic [SYM_W-1:0] c;
  logic [LEN_W-1:0] lencur, lenp;
  logic [POS_W-1:0] fposcur;
  info_t qinfo;

  logic [STAT_W-1:0] res_status;
  logic [ST_W-1:0] res_idx;
  logic [LEN_W-1:0] res_len;
  logic [POS_W-1:0] res_fpos;
  logic res_clone;

  logic ov;
  logic [STAT_W-1:0] o_status;
  logic [ST_W-1:0] o_idx;
  logic [LEN_W-1:0] o_len;
  logic [POS_W-1:0] o_fpos;
  logic o_clone;

  logic row_we;
  logic [ST_W-1:0] row_waddr, row_raddr;
  row_t row_wdata, row_rdata;
  logic info_we;
  logic [ST_W-1:0] info_waddr, info_raddr;
  info_t info_wdata, info_rdata;

  logic accept, full_hit, out_free;
  logic [ST_W-1:0] edge_val;

  assign accept   = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);
  assign edge_val = row_rdata[c];
  assign full_hit = (info_rdata.len >= LEN_W'(MAX_TEXT)) || (cnt >= CNT_W'(NSTATES - 1));
  assign out_free = !ov || rsp.ready;

  sam_ram #(.DATA_W($bits(row_t)), .ADDR_W(ST_W)) u_rows (
    .clk(clk), .we(row_we), .waddr(row_waddr), .wdata(row_wdata),
    .raddr(row_raddr), .rdata(row_rdata)
  );

  sam_ram #(.DATA_W($bits(info_t)), .ADDR_W(ST_W)) u_info (
    .clk(clk), .we(info_we), .waddr(info_waddr), .wdata(info_wdata),
    .raddr(info_raddr), .rdata(info_rdata)
  );

  always_comb begin
    row_we     = 1'b0;
    row_waddr  = p;
    row_wdata  = row_rdata;
    row_raddr  = p;
    info_we    = 1'b0;
    info_waddr = cur;
    info_wdata = '0;
    info_raddr = p;
    unique case (state)
      S_INIT: begin
        row_we     = 1'b1;
        row_waddr  = '0;
        row_wdata  = '0;
        info_we    = 1'b1;
        info_waddr = '0;
      end
      S_IDLE: begin
        row_raddr  = req.first ? '0 : cursor;
        info_raddr = last;
      end
      S_QRD: begin
        info_raddr = edge_val;
      end
      S_QINFO: ;
      S_XLAST: begin
        if (!full_hit) begin
          row_we     = 1'b1;
          row_waddr  = cnt[ST_W-1:0];
          row_wdata  = '0;
          info_we    = 1'b1;
          info_waddr = cnt[ST_W-1:0];
          info_wdata = '{len: info_rdata.len + LEN_W'(1), link: '0, clone: 1'b0,
                         fpos: info_rdata.len[POS_W-1:0]};
        end
      end
      S_WRD, S_CRD: ;
      S_WCHK: begin
        info_raddr = edge_val;
        if (edge_val == '0) begin
          row_we       = 1'b1;
          row_wdata[c] = cur;
        end
      end
      S_FQ: begin
        row_raddr = q;
        info_we   = 1'b1;
        if (lenp + LEN_W'(1) == info_rdata.len) begin
          info_waddr = cur;
          info_wdata = '{len: lencur, link: q, clone: 1'b0, fpos: fposcur};
        end else begin
          info_waddr = cnt[ST_W-1:0];
          info_wdata = '{len: lenp + LEN_W'(1), link: info_rdata.link, clone: 1'b1,
                         fpos: info_rdata.fpos};
        end
      end
      S_CCP: begin
        row_we    = 1'b1;
        row_waddr = cl;
      end
      S_CCHK: begin
        if (edge_val != q || p == '0) begin
          info_we    = 1'b1;
          info_waddr = q;
          info_wdata = '{len: qinfo.len, link: cl, clone: qinfo.clone, fpos: qinfo.fpos};
        end
        if (edge_val == q) begin
          row_we       = 1'b1;
          row_wdata[c] = cl;
        end
      end
      S_CLINK: begin
        info_we    = 1'b1;
        info_waddr = cur;
        info_wdata = '{len: lencur, link: cl, clone: 1'b0, fpos: fposcur};
      end
      S_FIN: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_INIT;
      from_clear <= 1'b0;
      ov         <= 1'b0;
      cnt        <= CNT_W'(1);
      last       <= '0;
      cursor     <= '0;
      lost       <= 1'b0;
    end else begin
      if ((state == S_FIN) && out_free) begin
        ov <= 1'b1;
      end else if (rsp.ready) begin
        ov <= 1'b0;
      end
      unique case (state)
        S_INIT: begin
          res_status <= STAT_OK;
          res_idx    <= '0;
          res_len    <= '0;
          res_fpos   <= '0;
          res_clone  <= 1'b0;
          state      <= from_clear ? S_FIN : S_IDLE;
        end
        S_IDLE: begin
          if (accept) begin
            c          <= req.symbol[SYM_W-1:0];
            res_status <= STAT_OK;
            res_idx    <= '0;
            res_len    <= '0;
            res_fpos   <= '0;
            res_clone  <= 1'b0;
            unique case (req.opcode)
              OP_CLEAR: begin
                cnt        <= CNT_W'(1);
                last       <= '0;
                cursor     <= '0;
                lost       <= 1'b0;
                from_clear <= 1'b1;
                state      <= S_INIT;
              end
              OP_EXTEND: state <= S_XLAST;
              OP_QUERY: begin
                if (req.first) begin
                  cursor <= '0;
                  lost   <= 1'b0;
                end
                if (lost && !req.first) begin
                  res_status <= STAT_MISS;
                  state      <= S_FIN;
                end else begin
                  state <= S_QRD;
                end
              end
              default: state <= S_FIN;
            endcase
          end
        end
        S_QRD: begin
          if (edge_val == '0) begin
            lost       <= 1'b1;
            res_status <= STAT_MISS;
            state      <= S_FIN;
          end else begin
            cursor <= edge_val;
            state  <= S_QINFO;
          end
        end
        S_QINFO: begin
          res_idx   <= cursor;
          res_len   <= info_rdata.len;
          res_fpos  <= info_rdata.fpos;
          res_clone <= info_rdata.clone;
          state     <= S_FIN;
        end
        S_XLAST: begin
          if (full_hit) begin
            res_status <= STAT_FULL;
            state      <= S_FIN;
          end else begin
            cur     <= cnt[ST_W-1:0];
            cnt     <= cnt + CNT_W'(1);
            lencur  <= info_rdata.len + LEN_W'(1);
            fposcur <= info_rdata.len[POS_W-1:0];
            p       <= last;
            state   <= S_WRD;
          end
        end
        S_WRD: state <= S_WCHK;
        S_WCHK: begin
          if (edge_val != '0) begin
            q     <= edge_val;
            lenp  <= info_rdata.len;
            state <= S_FQ;
          end else if (p == '0) begin
            state <= S_CLINK;
            cl    <= '0;
          end else begin
            p     <= info_rdata.link;
            state <= S_WRD;
          end
        end
        S_FQ: begin
          if (lenp + LEN_W'(1) == info_rdata.len) begin
            cl    <= q;
            state <= S_CLINK;
          end else begin
            qinfo <= info_rdata;
            cl    <= cnt[ST_W-1:0];
            cnt   <= cnt + CNT_W'(1);
            state <= S_CCP;
          end
        end
        S_CCP: state <= S_CRD;
        S_CRD: state <= S_CCHK;
        S_CCHK: begin
          if (edge_val != q || p == '0) begin
            state <= S_CLINK;
          end else begin
            p     <= info_rdata.link;
            state <= S_CRD;
          end
        end
        S_CLINK: begin
          last      <= cur;
          res_idx   <= cur;
          res_len   <= lencur;
          res_fpos  <= fposcur;
          res_clone <= 1'b0;
          state     <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            o_status   <= res_status;
            o_idx      <= res_idx;
            o_len      <= res_len;
            o_fpos     <= res_fpos;
            o_clone    <= res_clone;
            from_clear <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign rsp.valid        = ov;
  assign rsp.status       = o_status;
  assign rsp.state_index  = IDX_OW'(o_idx);
  assign rsp.state_length = LEN_OW'(o_len);
  assign rsp.first_end    = POS_OW'(o_fpos);
  assign rsp.clone_mark   = o_clone;

  `SAM_ASSERT(a_cnt_range, (cnt >= CNT_W'(1)) && (cnt <= CNT_W'(NSTATES)), "state count out of range")
  `SAM_ASSERT(a_last_live, {1'b0, last} < cnt, "last state not allocated")
  `SAM_ASSERT(a_cursor_live, lost || ({1'b0, cursor} < cnt), "query cursor not allocated")
  `SAM_ASSERT_IMP(a_fin_out, (state == S_FIN) && out_free, ov, "finished item not delivered")
endmodule
